FILE: design/gmcu_pkg.sv
`timescale 1ns / 1ps

package gmcu_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int EW = PW + 1;

  localparam logic [23:0] GAIN_ONE   = 24'd65536;
  localparam logic [23:0] GAIN_RISE  = 24'd13107;
  localparam logic [15:0] GAIN_DECAY = 16'd52429;
  localparam logic [23:0] GAIN_FLOOR = 24'd655;
  localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_GRAD = 2'd1,
    OP_END  = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_POINTS = 3'd0,
    CFG_RATE   = 3'd1,
    CFG_MOM0   = 3'd2,
    CFG_MOM1   = 3'd3,
    CFG_SWITCH = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_G1, S_G2, S_G3, S_G4, S_G5, S_SUM, S_DIV, S_SUB, S_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) return 32'h7FFFFFFF;
    if (v < -34'sh080000000) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

FILE: design/gmcu_if.sv
`timescale 1ns / 1ps

interface gmcu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  point_index;
  logic        dimension;
  logic signed [31:0] operand_value;
  modport source (output valid, opcode, point_index, dimension, operand_value, input ready);
  modport sink   (input valid, opcode, point_index, dimension, operand_value, output ready);
endinterface

interface gmcu_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] coordinate_value;
  logic [15:0] iterations_done;
  modport source (output valid, coordinate_value, iterations_done, input ready);
  modport sink   (input valid, coordinate_value, iterations_done, output ready);
endinterface

FILE: design/gain_momentum_coordinate_update_unit.sv
`timescale 1ns / 1ps

// Keeps position, velocity and gain of every point coordinate in on-chip RAMs
// and handles one word at a time. A load goes straight to the output register; a
// read first does one RAM read, and a gradient a RAM read and then a chain of
// registered multiplies for gain update, momentum and eta*gain*gradient. The
// next input word is taken in the cycle after the result leaves. An end of
// iteration sums each dimension over a full read sweep, divides it bit-serially
// for the mean, then sweeps again to subtract it. A result word is held in an
// output register until taken.
module gain_momentum_coordinate_update_unit (
  input  logic        clk,
  input  logic        rst_n,
  gmcu_in_if.sink     in_ch,
  gmcu_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);
  localparam int EW = gmcu_pkg::EW;

  logic [10:0] points_r;
  logic [25:0] rate_r;
  logic [15:0] mom0_r, mom1_r, switch_r;
  logic [15:0] iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= 11'd1024;
      rate_r   <= 26'd13107200;
      mom0_r   <= 16'd32768;
      mom1_r   <= 16'd52429;
      switch_r <= 16'd250;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmcu_pkg::CFG_POINTS: points_r <= cfg_data[10:0];
        gmcu_pkg::CFG_RATE:   rate_r   <= cfg_data;
        gmcu_pkg::CFG_MOM0:   mom0_r   <= cfg_data[15:0];
        gmcu_pkg::CFG_MOM1:   mom1_r   <= cfg_data[15:0];
        gmcu_pkg::CFG_SWITCH: switch_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [10:0] n_act;
  assign n_act = (points_r == 11'd0) ? 11'd1 :
                 (points_r > 11'(gmcu_pkg::MAX_POINTS)) ? 11'(gmcu_pkg::MAX_POINTS) : points_r;

  // Memories: positions in one, velocity and gain side by side in the other.
  logic signed [31:0] pos_mem [2*gmcu_pkg::MAX_POINTS];
  logic [55:0]        vg_mem  [2*gmcu_pkg::MAX_POINTS];
  logic [EW-1:0] raddr, waddr;
  logic          pos_we, vg_we;
  logic signed [31:0] pos_wd, vel_wd, pos_rd, vel_rd;
  logic [23:0]   gain_wd, gain_rd;
  logic [55:0]   vg_rd;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[waddr] <= pos_wd;
    if (vg_we) vg_mem[waddr] <= {vel_wd, gain_wd};
    pos_rd <= pos_mem[raddr];
    vg_rd  <= vg_mem[raddr];
  end

  assign vel_rd  = vg_rd[55:24];
  assign gain_rd = vg_rd[23:0];

  gmcu_pkg::state_t state_r, state_nxt;
  gmcu_pkg::opcode_t op_r;
  logic [EW-1:0] ent_r;
  logic          dim_r;
  logic signed [31:0] val_r;
  logic          ok_r;
  logic          ovalid_r;
  logic signed [31:0] ocoord_r;

  // Gradient pipeline registers.
  logic [23:0] g_r;
  logic signed [31:0] v_r, p_r, nv_r;
  logic [47:0] mv_r;
  logic [49:0] rg_r;
  logic [31:0] ag_r;
  logic [63:0] plo_r;
  logic [49:0] phi_r;
  logic [32:0] inert_r;
  logic [50:0] step_w;
  logic [33:0] push_w;
  // Mean pass.
  logic [10:0] cnt_r;
  logic        sweep_r;
  logic signed [42:0] sum_r;
  logic signed [31:0] mean_r;
  logic        div_start;
  logic        div_done;
  logic [42:0] div_q, div_in;

  assign div_in = sum_r[42] ? 43'(-sum_r) + 43'(n_act >> 1) : 43'(sum_r) + 43'(n_act >> 1);

  gmcu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_in), .divisor(n_act),
    .done(div_done), .quotient(div_q)
  );

  assign in_ch.ready = (state_r == gmcu_pkg::S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.coordinate_value = ocoord_r;
  assign out_ch.iterations_done = iter_r;

  logic [EW-1:0] in_ent;
  assign in_ent = {in_ch.point_index[gmcu_pkg::PW-1:0], in_ch.dimension};

  // A push of 2^32 or more saturates the velocity whatever the inertia is.
  assign step_w = 51'(phi_r) + 51'((65'(plo_r) + 65'h80000000) >> 32);
  assign push_w = (step_w > 51'h1_0000_0000) ? 34'h1_0000_0000 : 34'(step_w);

  logic [23:0] g_new;
  logic [24:0] g_rise;
  logic [39:0] g_dec;
  logic [15:0] mom;
  always_comb begin
    g_rise = {1'b0, gain_rd} + {1'b0, gmcu_pkg::GAIN_RISE};
    g_dec  = gain_rd * gmcu_pkg::GAIN_DECAY + 40'd32768;
    if ((val_r > 0) != (vel_rd > 0) || (val_r < 0) != (vel_rd < 0))
      g_new = g_rise[24] ? gmcu_pkg::GAIN_MAX : g_rise[23:0];
    else
      g_new = g_dec[39:16];
    if (g_new < gmcu_pkg::GAIN_FLOOR) g_new = gmcu_pkg::GAIN_FLOOR;
    mom = (iter_r <= switch_r) ? mom0_r : mom1_r;
  end

  logic [EW-1:0] sweep_addr;
  assign sweep_addr = {cnt_r[gmcu_pkg::PW-1:0], dim_r};

  always_comb begin
    state_nxt = state_r;
    raddr = (state_r == gmcu_pkg::S_IDLE) ? in_ent : ent_r;
    waddr = ent_r;
    pos_we = 1'b0;
    vg_we = 1'b0;
    pos_wd = val_r;
    vel_wd = '0;
    gain_wd = gmcu_pkg::GAIN_ONE;
    div_start = 1'b0;
    unique case (state_r)
      gmcu_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == gmcu_pkg::OP_END) state_nxt = gmcu_pkg::S_SUM;
        else if (in_ch.opcode == gmcu_pkg::OP_LOAD) state_nxt = gmcu_pkg::S_OUT;
        else state_nxt = gmcu_pkg::S_RD;
      end
      gmcu_pkg::S_RD: state_nxt = (op_r == gmcu_pkg::OP_GRAD && ok_r) ?
                                  gmcu_pkg::S_G1 : gmcu_pkg::S_OUT;
      gmcu_pkg::S_G1: state_nxt = gmcu_pkg::S_G2;
      gmcu_pkg::S_G2: state_nxt = gmcu_pkg::S_G3;
      gmcu_pkg::S_G3: state_nxt = gmcu_pkg::S_G4;
      gmcu_pkg::S_G4: state_nxt = gmcu_pkg::S_G5;
      gmcu_pkg::S_G5: begin
        pos_we = 1'b1;
        vg_we = 1'b1;
        pos_wd = gmcu_pkg::sat32(34'(p_r) + 34'(nv_r));
        vel_wd = nv_r;
        gain_wd = g_r;
        state_nxt = gmcu_pkg::S_OUT;
      end
      gmcu_pkg::S_SUM: begin
        raddr = sweep_addr;
        if (sweep_r && cnt_r == n_act) state_nxt = gmcu_pkg::S_DIV;
      end
      // The last sum term lands as the state is entered, so the divider
      // starts on entry to the state, while sweep_r is still set.
      gmcu_pkg::S_DIV: begin
        div_start = sweep_r;
        if (div_done) state_nxt = gmcu_pkg::S_SUB;
      end
      gmcu_pkg::S_SUB: begin
        raddr = sweep_addr;
        waddr = {ent_r[EW-1:1], dim_r};
        pos_we = sweep_r;
        pos_wd = gmcu_pkg::sat32(34'(pos_rd) - 34'(mean_r));
        if (sweep_r && {1'b0, ent_r[EW-1:1]} == n_act - 11'd1) state_nxt =
          dim_r ? gmcu_pkg::S_OUT : gmcu_pkg::S_SUM;
      end
      gmcu_pkg::S_OUT: begin
        if (op_r == gmcu_pkg::OP_LOAD && ok_r) begin
          pos_we = 1'b1;
          vg_we = 1'b1;
        end
        state_nxt = gmcu_pkg::S_IDLE;
      end
      default: state_nxt = gmcu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmcu_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      iter_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      if (state_r == gmcu_pkg::S_OUT) ovalid_r <= 1'b1;
      if (state_r == gmcu_pkg::S_SUB && state_nxt == gmcu_pkg::S_OUT && iter_r != 16'hFFFF)
        iter_r <= iter_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      gmcu_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_r  <= gmcu_pkg::opcode_t'(in_ch.opcode);
          ent_r <= in_ent;
          val_r <= in_ch.operand_value;
          ok_r  <= 32'(in_ch.point_index) < 32'(gmcu_pkg::MAX_POINTS);
          dim_r <= 1'b0;
          cnt_r <= '0;
          sweep_r <= 1'b0;
          sum_r <= '0;
          ocoord_r <= (in_ch.opcode == gmcu_pkg::OP_LOAD &&
                       32'(in_ch.point_index) < 32'(gmcu_pkg::MAX_POINTS)) ?
                      in_ch.operand_value : '0;
        end
      end
      gmcu_pkg::S_RD: begin
        if (op_r == gmcu_pkg::OP_READ && ok_r) ocoord_r <= pos_rd;
      end
      gmcu_pkg::S_G1: begin
        g_r <= g_new;
        v_r <= vel_rd;
        p_r <= pos_rd;
        ag_r <= val_r[31] ? 32'(-val_r) : 32'(val_r);
        mv_r <= mom * (vel_rd[31] ? 32'(-vel_rd) : 32'(vel_rd)) + 48'd32768;
      end
      gmcu_pkg::S_G2: begin
        rg_r <= rate_r * g_r;
        inert_r <= v_r[31] ? 33'(-$signed({1'b0, mv_r[47:16]})) : {1'b0, mv_r[47:16]};
      end
      gmcu_pkg::S_G3: begin
        plo_r <= rg_r[31:0] * ag_r;
        phi_r <= 50'(rg_r[49:32]) * 50'(ag_r);
      end
      gmcu_pkg::S_G4: begin
        nv_r <= gmcu_pkg::sat32(34'($signed(inert_r)) - (val_r[31] ? -push_w : push_w));
      end
      gmcu_pkg::S_G5: ocoord_r <= gmcu_pkg::sat32(34'(p_r) + 34'(nv_r));
      gmcu_pkg::S_SUM: begin
        if (sweep_r) sum_r <= sum_r + 43'(pos_rd);
        sweep_r <= 1'b1;
        cnt_r <= cnt_r + 11'd1;
      end
      gmcu_pkg::S_DIV: begin
        mean_r <= sum_r[42] ? -32'(div_q) : 32'(div_q);
        cnt_r <= '0;
        sweep_r <= 1'b0;
      end
      gmcu_pkg::S_SUB: begin
        ent_r <= {cnt_r[gmcu_pkg::PW-1:0], dim_r};
        if (state_nxt == gmcu_pkg::S_SUM) begin
          dim_r <= 1'b1;
          cnt_r <= '0;
          sweep_r <= 1'b0;
          sum_r <= '0;
        end else begin
          cnt_r <= cnt_r + 11'd1;
          sweep_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: design/gmcu_div.sv
`timescale 1ns / 1ps

// Restoring divider: 43-bit magnitude by an up-to-11-bit count, one bit a cycle.
module gmcu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [42:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [42:0] quotient
);
  logic [42:0] q_r;
  logic [11:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [11:0] trial;

  assign trial = {rem_r[10:0], q_r[42]};
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= 6'd43;
      end else if (busy_r) begin
        if (trial >= {1'b0, divisor}) begin
          rem_r <= trial - {1'b0, divisor};
          q_r   <= {q_r[41:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[41:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [31:0] coord;
    logic [15:0] iter;
  } result_t;

  typedef struct {
    gmcu_pkg::opcode_t op;
    logic [9:0]  pt;
    logic        dim;
    logic [31:0] val;
    bit          typed;
    logic [31:0] coord;
    logic [15:0] iter;
  } row_t;

  typedef struct {
    logic [10:0] pts;
    logic [25:0] rate;
    logic [15:0] m0;
    logic [15:0] m1;
    logic [15:0] sw;
  } setting_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [25:0] cfg_data = '0;

  gmcu_in_if  in_ch();
  gmcu_out_if out_ch();

  gain_momentum_coordinate_update_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the coordinate tables and settings.
  logic signed [31:0] pos_mem [2*gmcu_pkg::MAX_POINTS];
  logic signed [31:0] vel_mem [2*gmcu_pkg::MAX_POINTS];
  logic [23:0]        gain_mem[2*gmcu_pkg::MAX_POINTS];
  bit                 loaded  [2*gmcu_pkg::MAX_POINTS];
  logic [15:0] iter_cnt;
  logic [10:0] n_use;
  logic [25:0] eta;
  logic [15:0] mom_early, mom_late, switch_iter;

  result_t coord_q[$];
  row_t    rows[$];
  int errors = 0;
  int n_items = 0;
  int n_ends = 0;
  int n_checked = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit offering = 0;

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFFFFFF;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic int sign_of(longint x);
    return (x > 0) - (x < 0);
  endfunction

  function automatic longint unsigned mag_of(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic int points_used();
    if (n_use == 0) return 1;
    if (n_use > gmcu_pkg::MAX_POINTS) return gmcu_pkg::MAX_POINTS;
    return n_use;
  endfunction

  function automatic bit all_loaded(int n);
    for (int e = 0; e < 2 * n; e++)
      if (!loaded[e]) return 0;
    return 1;
  endfunction

  function automatic int first_unloaded(int n);
    for (int e = 0; e < 2 * n; e++)
      if (!loaded[e]) return e;
    return 0;
  endfunction

  function automatic result_t predict_word(gmcu_pkg::opcode_t op, logic [9:0] pt, logic dim,
                                           logic [31:0] val);
    result_t r;
    int e;
    int n;
    longint v, grad, sum, mean, inertia, push, nv;
    longint unsigned g, mom, rg, hi, lo, ag, step, m;
    e = pt * 2 + dim;
    r.coord = '0;
    case (op)
      gmcu_pkg::OP_LOAD: begin
        pos_mem[e] = val;
        vel_mem[e] = '0;
        gain_mem[e] = gmcu_pkg::GAIN_ONE;
        loaded[e] = 1;
        r.coord = val;
      end
      gmcu_pkg::OP_GRAD: begin
        v = vel_mem[e];
        grad = $signed(val);
        g = gain_mem[e];
        if (sign_of(grad) != sign_of(v)) begin
          g = g + gmcu_pkg::GAIN_RISE;
          if (g > gmcu_pkg::GAIN_MAX) g = gmcu_pkg::GAIN_MAX;
        end else begin
          g = (g * gmcu_pkg::GAIN_DECAY + 32768) >> 16;
        end
        if (g < gmcu_pkg::GAIN_FLOOR) g = gmcu_pkg::GAIN_FLOOR;
        gain_mem[e] = g[23:0];
        mom = (iter_cnt <= switch_iter) ? mom_early : mom_late;
        m = (mom * mag_of(v) + 32768) >> 16;
        inertia = (v < 0) ? -longint'(m) : longint'(m);
        rg = eta * g;
        ag = mag_of(grad);
        hi = rg >> 32;
        lo = rg & 64'hFFFF_FFFF;
        step = hi * ag + ((lo * ag + 64'h8000_0000) >> 32);
        push = (grad < 0) ? -longint'(step) : longint'(step);
        nv = $signed(clamp32(inertia - push));
        vel_mem[e] = nv[31:0];
        pos_mem[e] = clamp32(longint'(pos_mem[e]) + nv);
        r.coord = pos_mem[e];
      end
      gmcu_pkg::OP_END: begin
        n = points_used();
        for (int d = 0; d < 2; d++) begin
          sum = 0;
          for (int p = 0; p < n; p++) sum += pos_mem[p*2+d];
          m = (mag_of(sum) + n / 2) / n;
          mean = (sum < 0) ? -longint'(m) : longint'(m);
          for (int p = 0; p < n; p++)
            pos_mem[p*2+d] = clamp32(longint'(pos_mem[p*2+d]) - mean);
        end
        if (iter_cnt != 16'hFFFF) iter_cnt++;
      end
      default: r.coord = pos_mem[e];
    endcase
    r.iter = iter_cnt;
    return r;
  endfunction

  task automatic offer_word(gmcu_pkg::opcode_t op, logic [9:0] pt, logic dim,
                            logic [31:0] val, bit typed = 0, logic [31:0] tc = '0,
                            logic [15:0] ti = '0);
    result_t r;
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.point_index <= pt;
    in_ch.dimension <= dim;
    in_ch.operand_value <= val;
    offering = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_word(op, pt, dim, val);
    if (typed) begin
      r.coord = tc;
      r.iter = ti;
    end
    coord_q.push_back(r);
    n_items++;
    if (op == gmcu_pkg::OP_END) n_ends++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 0;
      offering = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (offering) begin
      in_ch.valid <= 0;
      offering = 0;
    end
    while (coord_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(setting_t s);
    cfg_we <= 1; cfg_index <= gmcu_pkg::CFG_POINTS; cfg_data <= 26'(s.pts); @(posedge clk);
    cfg_index <= gmcu_pkg::CFG_RATE;   cfg_data <= s.rate;      @(posedge clk);
    cfg_index <= gmcu_pkg::CFG_MOM0;   cfg_data <= 26'(s.m0);   @(posedge clk);
    cfg_index <= gmcu_pkg::CFG_MOM1;   cfg_data <= 26'(s.m1);   @(posedge clk);
    cfg_index <= gmcu_pkg::CFG_SWITCH; cfg_data <= 26'(s.sw);   @(posedge clk);
    cfg_we <= 0;
    n_use = s.pts; eta = s.rate; mom_early = s.m0; mom_late = s.m1; switch_iter = s.sw;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: case ($urandom_range(0, 4))
           0: return 32'h7FFFFFFF;
           1: return 32'h80000000;
           2: return 32'h00000000;
           3: return 32'h00000001;
           default: return 32'hFFFFFFFF;
         endcase
      default: return $signed($urandom) >>> 10;
    endcase
  endfunction

  task automatic random_words(int count);
    gmcu_pkg::opcode_t op;
    logic [9:0] pt;
    logic dim;
    int k, e;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      op = (k < 10) ? gmcu_pkg::OP_LOAD : (k < 65) ? gmcu_pkg::OP_GRAD :
           (k < 70) ? gmcu_pkg::OP_END : gmcu_pkg::OP_READ;
      pt = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      dim = 1'($urandom);
      e = pt * 2 + dim;
      // Never touch an entry that holds no coordinate yet.
      if ((op == gmcu_pkg::OP_GRAD || op == gmcu_pkg::OP_READ) && !loaded[e])
        op = gmcu_pkg::OP_LOAD;
      if (op == gmcu_pkg::OP_END && !all_loaded(points_used())) begin
        op = gmcu_pkg::OP_LOAD;
        e = first_unloaded(points_used());
        pt = 10'(e / 2);
        dim = 1'(e % 2);
      end
      offer_word(op, pt, dim, pick_operand());
    end
  endtask

  task automatic add_row(gmcu_pkg::opcode_t op, logic [9:0] pt, logic dim, logic [31:0] val,
                         bit typed = 0, logic [31:0] c = '0, logic [15:0] it = '0);
    row_t r;
    r.op = op; r.pt = pt; r.dim = dim; r.val = val;
    r.typed = typed; r.coord = c; r.iter = it;
    rows.push_back(r);
  endtask

  // Result side: random back-pressure and a long hold-off when asked.
  initial begin
    result_t x;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (coord_q.size() == 0) begin
          $display("%0t: unexpected word coord=%h iter=%0d", $time,
                   out_ch.coordinate_value, out_ch.iterations_done);
          errors++;
        end else begin
          x = coord_q.pop_front();
          n_checked++;
          if (out_ch.coordinate_value !== x.coord) begin
            $display("%0t: coordinate expected %h actual %h", $time, x.coord,
                     out_ch.coordinate_value);
            errors++;
          end
          if (out_ch.iterations_done !== x.iter) begin
            $display("%0t: iterations expected %0d actual %0d", $time, x.iter,
                     out_ch.iterations_done);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 9) != 0);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    setting_t phases[8];
    setting_t s;
    in_ch.valid = 0;
    in_ch.opcode = gmcu_pkg::OP_LOAD;
    in_ch.point_index = '0;
    in_ch.dimension = 0;
    in_ch.operand_value = '0;
    iter_cnt = '0;
    foreach (loaded[i]) loaded[i] = 0;
    n_use = 1024; eta = 13107200; mom_early = 32768; mom_late = 52429; switch_iter = 250;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    s = '{pts: 2, rate: 13107200, m0: 32768, m1: 52429, sw: 0};
    apply_setting(s);
    add_row(gmcu_pkg::OP_LOAD, 0, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0);
    add_row(gmcu_pkg::OP_LOAD, 0, 1, 32'h80000000, 1, 32'h80000000, 0);
    add_row(gmcu_pkg::OP_LOAD, 1, 0, 32'h00000000, 1, 32'h00000000, 0);
    add_row(gmcu_pkg::OP_LOAD, 1, 1, 32'h00010000, 1, 32'h00010000, 0);
    add_row(gmcu_pkg::OP_LOAD, 1023, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 0);
    add_row(gmcu_pkg::OP_READ, 1023, 1, 32'h12345678, 1, 32'hFFFFFFFF, 0);
    add_row(gmcu_pkg::OP_READ, 0, 0, 32'h0, 1, 32'h7FFFFFFF, 0);
    add_row(gmcu_pkg::OP_GRAD, 0, 0, 32'h80000000);
    add_row(gmcu_pkg::OP_GRAD, 0, 1, 32'h7FFFFFFF);
    add_row(gmcu_pkg::OP_GRAD, 1, 0, 32'h00000000);
    add_row(gmcu_pkg::OP_GRAD, 1, 1, 32'h00010000);
    add_row(gmcu_pkg::OP_GRAD, 1, 1, 32'hFFFF0000);
    add_row(gmcu_pkg::OP_END, 0, 0, 32'h0, 1, 32'h0, 1);
    add_row(gmcu_pkg::OP_READ, 0, 0, 32'h0);
    add_row(gmcu_pkg::OP_READ, 0, 1, 32'h0);
    add_row(gmcu_pkg::OP_GRAD, 1, 0, 32'h00012345);
    add_row(gmcu_pkg::OP_END, 1023, 1, 32'hFFFFFFFF, 1, 32'h0, 2);
    add_row(gmcu_pkg::OP_LOAD, 512, 0, 32'h55555555, 1, 32'h55555555, 2);
    add_row(gmcu_pkg::OP_GRAD, 512, 0, 32'hAAAAAAAA);
    add_row(gmcu_pkg::OP_READ, 512, 0, 32'h0);
    foreach (rows[i])
      offer_word(rows[i].op, rows[i].pt, rows[i].dim, rows[i].val,
                 rows[i].typed, rows[i].coord, rows[i].iter);
    drain();

    phases[0] = '{pts: 64,   rate: 13107200, m0: 32768, m1: 52429, sw: 250};
    phases[1] = '{pts: 1,    rate: 0,        m0: 0,     m1: 65535, sw: 0};
    phases[2] = '{pts: 7,    rate: 67108863, m0: 65535, m1: 0,     sw: 65535};
    phases[3] = '{pts: 0,    rate: 655360,   m0: 52429, m1: 32768, sw: 2};
    phases[4] = '{pts: 2047, rate: 1310720,  m0: 16384, m1: 60000, sw: 3};
    phases[5] = '{pts: 1024, rate: 65536,    m0: 32768, m1: 52429, sw: 0};
    phases[6] = '{pts: 33,   rate: 3276800,  m0: 40000, m1: 50000, sw: 20};
    phases[7] = '{pts: 64,   rate: 26214400, m0: 1,     m1: 65534, sw: 1};

    // The first 64 points hold coordinates before any mean is taken over them.
    apply_setting(phases[0]);
    for (int e = 0; e < 128; e++)
      if (!loaded[e]) offer_word(gmcu_pkg::OP_LOAD, 10'(e / 2), 1'(e % 2), pick_operand());
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        apply_setting(phases[p]);
      end
      calm = (p == 6);
      if (p == 0 || p == 6) hold_req = 1;
      random_words((p == 4 || p == 5) ? 60 : 115);
    end
    drain();
    calm = 0;
    repeat (100) @(posedge clk);

    $display("Covered %0d input words, %0d iteration ends, %0d results checked,",
             n_items, n_ends, n_checked);
    $display("over 9 register settings including the range limits.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
